FILE: rtl/core/pte_pkg.sv
package pte_pkg;

  localparam int unsigned NUM_COEF = 6;
  localparam int unsigned NUM_LANE = 3;
  localparam int unsigned WORD_W   = 48;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned DT_W     = TIME_W + 1;
  localparam int unsigned LO_W     = 32;
  localparam int unsigned HI_W     = WORD_W - LO_W;
  localparam int unsigned PLO_W    = LO_W + 1 + DT_W;
  localparam int unsigned PHI_W    = HI_W + DT_W;
  localparam int unsigned PROD_W   = WORD_W + DT_W;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned Q_W      = PROD_W - FRAC_W;
  localparam int unsigned WIDE_W   = Q_W + 1;
  localparam int unsigned PDATA_W  = 64;
  localparam int unsigned PADDR_W  = 6;
  localparam int unsigned REG_LSB  = 3;

  localparam int unsigned LANE_POS = 0;
  localparam int unsigned LANE_VEL = 1;
  localparam int unsigned LANE_ACC = 2;

  typedef logic signed [WORD_W-1:0] pte_word_t;
  typedef logic signed [DT_W-1:0]   pte_dt_t;

  typedef enum logic [1:0] {
    PHASE_BEFORE = 2'd0,
    PHASE_RUN    = 2'd1,
    PHASE_DONE   = 2'd2
  } pte_phase_e;

  typedef enum logic [2:0] {
    REG_COEF_0     = 3'd0,
    REG_COEF_1     = 3'd1,
    REG_COEF_2     = 3'd2,
    REG_COEF_3     = 3'd3,
    REG_COEF_4     = 3'd4,
    REG_COEF_5     = 3'd5,
    REG_START_TIME = 3'd6,
    REG_DURATION   = 3'd7
  } pte_reg_e;

  // per-item sideband that rides along the pipeline
  typedef struct packed {
    pte_dt_t    dt;
    pte_phase_e phase;
    logic       sat;
  } pte_side_t;

  typedef struct packed {
    pte_word_t value;
    logic      clip;
  } pte_sat_t;

  // clip a wide signed value to the 48 bit range
  function automatic pte_sat_t pte_sat48(input logic signed [WIDE_W-1:0] x);
    pte_sat_t r;
    if ((&x[WIDE_W-1:WORD_W-1]) || !(|x[WIDE_W-1:WORD_W-1])) begin
      r.value = x[WORD_W-1:0];
      r.clip  = 1'b0;
    end else begin
      r.value = x[WIDE_W-1] ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
      r.clip  = 1'b1;
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/pte_horner_step.sv
module pte_horner_step (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  pte_pkg::pte_side_t  side_i,
  input  pte_pkg::pte_word_t  acc_i  [pte_pkg::NUM_LANE],
  input  pte_pkg::pte_word_t  coef_i [pte_pkg::NUM_LANE],
  output logic                valid_o,
  output pte_pkg::pte_side_t  side_o,
  output pte_pkg::pte_word_t  acc_o  [pte_pkg::NUM_LANE]
);
  import pte_pkg::*;

  // stage 1: low partial product
  logic                     v1_q;
  pte_side_t                side1_q;
  logic signed [PLO_W-1:0]  plo1_q [NUM_LANE];
  logic signed [HI_W-1:0]   hi1_q  [NUM_LANE];
  logic                     neg1_q [NUM_LANE];
  // stage 2: high partial product
  logic                     v2_q;
  pte_side_t                side2_q;
  logic signed [PLO_W-1:0]  plo2_q [NUM_LANE];
  logic signed [PHI_W-1:0]  phi2_q [NUM_LANE];
  logic                     neg2_q [NUM_LANE];
  // stage 3: combine and round
  logic                     v3_q;
  pte_side_t                side3_q;
  logic signed [Q_W-1:0]    q3_q   [NUM_LANE];
  // stage 4: add coefficient and clip
  logic                     v4_q;
  pte_side_t                side4_q;
  pte_word_t                acc4_q [NUM_LANE];

  logic signed [PLO_W-1:0]  plo1_d [NUM_LANE];
  logic signed [PHI_W-1:0]  phi2_d [NUM_LANE];
  logic signed [PROD_W-1:0] prod3  [NUM_LANE];
  logic signed [Q_W-1:0]    q3_d   [NUM_LANE];
  logic signed [WIDE_W-1:0] sum4   [NUM_LANE];
  pte_sat_t                 sat4   [NUM_LANE];
  pte_side_t                side4_d;

  always_comb begin
    side4_d = side3_q;
    for (int l = 0; l < NUM_LANE; l++) begin
      plo1_d[l] = $signed({1'b0, acc_i[l][LO_W-1:0]}) * $signed(side_i.dt);
      phi2_d[l] = $signed(hi1_q[l]) * $signed(side1_q.dt);
      prod3[l]  = $signed({phi2_q[l], {LO_W{1'b0}}})
                + $signed({{(PROD_W-PLO_W){plo2_q[l][PLO_W-1]}}, plo2_q[l]})
                + $signed({{(PROD_W-FRAC_W){1'b0}},
                           (neg2_q[l] ? 16'h7fff : 16'h8000)});
      // floor after the bias gives round half away from zero
      q3_d[l]   = prod3[l][PROD_W-1:FRAC_W];
      sum4[l]   = $signed({q3_q[l][Q_W-1], q3_q[l]})
                + $signed({{(WIDE_W-WORD_W){coef_i[l][WORD_W-1]}}, coef_i[l]});
      sat4[l]   = pte_sat48(sum4[l]);
      side4_d.sat = side4_d.sat | sat4[l].clip;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side1_q <= side_i;
      side2_q <= side1_q;
      side3_q <= side2_q;
      side4_q <= side4_d;
      for (int l = 0; l < NUM_LANE; l++) begin
        plo1_q[l] <= plo1_d[l];
        hi1_q[l]  <= acc_i[l][WORD_W-1:LO_W];
        neg1_q[l] <= acc_i[l][WORD_W-1] ^ side_i.dt[DT_W-1];
        plo2_q[l] <= plo1_q[l];
        phi2_q[l] <= phi2_d[l];
        neg2_q[l] <= neg1_q[l];
        q3_q[l]   <= q3_d[l];
        acc4_q[l] <= sat4[l].value;
      end
    end
  end

  assign valid_o = v4_q;
  assign side_o  = side4_q;
  assign acc_o   = acc4_q;

endmodule

FILE: rtl/core/poly_trajectory_evaluator_top.sv
// a sample passes the front offset register, then the Horner steps, then the output register
// throughput: one transfer per cycle while the skid slot is empty; each Horner step is four register stages
//   (low partial product, high partial product, round, add and clip)
// input ready drops only while both the output register and its skid slot are full
// reset (async, active low) empties the pipeline and sets coefficients to 0,
//   start time to all ones and duration to 0
module poly_trajectory_evaluator_top #(
  parameter int POLY_ORDER = 5
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // sample channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [pte_pkg::TIME_W-1:0]    sample_time_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [pte_pkg::WORD_W-1:0] position_o,
  output logic signed [pte_pkg::WORD_W-1:0] velocity_o,
  output logic signed [pte_pkg::WORD_W-1:0] acceleration_o,
  output logic [1:0]                    phase_o,
  output logic                          saturated_o,
  // register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pte_pkg::PADDR_W-1:0]   paddr,
  input  logic [pte_pkg::PDATA_W-1:0]   pwdata,
  output logic [pte_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  import pte_pkg::*;

  // order is held to what the coefficient registers support
  localparam int NSTEP = (POLY_ORDER < 0) ? 0 :
                         ((POLY_ORDER > NUM_COEF - 1) ? NUM_COEF - 1 : POLY_ORDER);
  localparam int NDER  = NUM_COEF - 1;

  typedef struct packed {
    pte_word_t  position;
    pte_word_t  velocity;
    pte_word_t  acceleration;
    pte_phase_e phase;
    logic       sat;
  } out_item_t;

  // ---------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------
  pte_word_t          coef_q [NUM_COEF];
  logic [TIME_W-1:0]  start_q;
  logic [TIME_W-1:0]  dur_q;
  logic               cfg_wr;
  pte_reg_e           reg_sel;

  assign cfg_wr  = psel && penable && pwrite;
  assign reg_sel = pte_reg_e'(paddr[REG_LSB+2:REG_LSB]);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_COEF; k++) begin
        coef_q[k] <= '0;
      end
      start_q <= '1;
      dur_q   <= '0;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_COEF_0, REG_COEF_1, REG_COEF_2,
        REG_COEF_3, REG_COEF_4, REG_COEF_5: begin
          coef_q[paddr[REG_LSB+2:REG_LSB]] <= pwdata[WORD_W-1:0];
        end
        REG_START_TIME: start_q <= pwdata[TIME_W-1:0];
        REG_DURATION:   dur_q   <= pwdata[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_COEF_0, REG_COEF_1, REG_COEF_2,
      REG_COEF_3, REG_COEF_4, REG_COEF_5: begin
        prdata = {{(PDATA_W-WORD_W){1'b0}}, coef_q[paddr[REG_LSB+2:REG_LSB]]};
      end
      REG_START_TIME: prdata = {{(PDATA_W-TIME_W){1'b0}}, start_q};
      REG_DURATION:   prdata = {{(PDATA_W-TIME_W){1'b0}}, dur_q};
      default:        prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------
  // derivative coefficients, refreshed every cycle from the registers
  // velocity uses (k+1)*c[k+1], acceleration uses (k+2)*(k+1)*c[k+2]
  // ---------------------------------------------------------------
  pte_word_t dcoef_q [NDER];
  pte_word_t acoef_q [NDER];
  logic [NDER-1:0] dclip_q;
  logic [NDER-1:0] aclip_q;
  logic [NDER-1:0] dclip_used;
  logic [NDER-1:0] aclip_used;
  logic            deriv_sat;

  for (genvar k = 0; k < NDER; k++) begin : g_deriv
    logic signed [WIDE_W-1:0] dprod;
    pte_sat_t                 dsat;
    assign dprod = $signed(coef_q[k+1]) * $signed({1'b0, 6'(k + 1)});
    assign dsat  = pte_sat48(dprod);

    always_ff @(posedge clk_i) begin
      dcoef_q[k] <= dsat.value;
      dclip_q[k] <= dsat.clip;
    end

    if (k + 2 < NUM_COEF) begin : g_acc
      logic signed [WIDE_W-1:0] aprod;
      pte_sat_t                 asat;
      assign aprod = $signed(coef_q[k+2]) * $signed({1'b0, 6'((k + 2) * (k + 1))});
      assign asat  = pte_sat48(aprod);
      always_ff @(posedge clk_i) begin
        acoef_q[k] <= asat.value;
        aclip_q[k] <= asat.clip;
      end
    end else begin : g_acc_none
      always_ff @(posedge clk_i) begin
        acoef_q[k] <= '0;
        aclip_q[k] <= 1'b0;
      end
    end

    // only the coefficients that the configured order reaches can flag a clip
    assign dclip_used[k] = (k < NSTEP)     ? dclip_q[k] : 1'b0;
    assign aclip_used[k] = (k < NSTEP - 1) ? aclip_q[k] : 1'b0;
  end

  assign deriv_sat = (|dclip_used) | (|aclip_used);

  // ---------------------------------------------------------------
  // pipeline control: one global enable, held only by a full skid slot
  // ---------------------------------------------------------------
  logic      en;
  logic      out_valid_q;
  logic      skid_v_q;
  out_item_t out_q;
  out_item_t skid_q;

  assign en         = !skid_v_q;
  assign in_ready_o = en;

  // front stage: time offset from trajectory start
  logic    v0_q;
  pte_dt_t dt0_q;
  pte_dt_t dt0_d;

  assign dt0_d = $signed({1'b0, sample_time_i}) - $signed({1'b0, start_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en) begin
      v0_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && in_valid_i) begin
      dt0_q <= dt0_d;
    end
  end

  // phase from the offset; a duration of all ones never finishes
  pte_phase_e phase0;

  always_comb begin
    if (dt0_q[DT_W-1]) begin
      phase0 = PHASE_BEFORE;
    end else if (&dur_q) begin
      phase0 = PHASE_RUN;
    end else if (dt0_q[TIME_W-1:0] < dur_q) begin
      phase0 = PHASE_RUN;
    end else begin
      phase0 = PHASE_DONE;
    end
  end

  // ---------------------------------------------------------------
  // Horner chain: entry 0 holds the leading coefficient for position and
  // zero for the derivative lanes (a leading zero step adds nothing)
  // ---------------------------------------------------------------
  logic      lane_v    [NSTEP+1];
  pte_side_t lane_side [NSTEP+1];
  pte_word_t lane_acc  [NSTEP+1][NUM_LANE];

  assign lane_v[0]              = v0_q;
  assign lane_side[0]           = '{dt: dt0_q, phase: phase0, sat: 1'b0};
  assign lane_acc[0][LANE_POS]  = coef_q[NSTEP];
  assign lane_acc[0][LANE_VEL]  = '0;
  assign lane_acc[0][LANE_ACC]  = '0;

  for (genvar j = 0; j < NSTEP; j++) begin : g_step
    localparam int K = NSTEP - 1 - j;
    pte_word_t step_coef [NUM_LANE];

    assign step_coef[LANE_POS] = coef_q[K];
    assign step_coef[LANE_VEL] = dcoef_q[K];
    assign step_coef[LANE_ACC] = (K + 2 <= NSTEP) ? acoef_q[K] : '0;

    pte_horner_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (lane_v[j]),
      .side_i  (lane_side[j]),
      .acc_i   (lane_acc[j]),
      .coef_i  (step_coef),
      .valid_o (lane_v[j+1]),
      .side_o  (lane_side[j+1]),
      .acc_o   (lane_acc[j+1])
    );
  end

  // ---------------------------------------------------------------
  // output register with one skid slot
  // ---------------------------------------------------------------
  logic      push;
  logic      pop;
  out_item_t new_item;

  assign push = en && lane_v[NSTEP];
  assign pop  = out_valid_q && out_ready_i;

  always_comb begin
    new_item.position     = lane_acc[NSTEP][LANE_POS];
    new_item.velocity     = lane_acc[NSTEP][LANE_VEL];
    new_item.acceleration = lane_acc[NSTEP][LANE_ACC];
    new_item.phase        = lane_side[NSTEP].phase;
    new_item.sat          = lane_side[NSTEP].sat | deriv_sat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      skid_v_q    <= 1'b0;
    end else begin
      if (skid_v_q) begin
        if (pop) skid_v_q <= 1'b0;
      end else if (push && out_valid_q && !pop) begin
        skid_v_q <= 1'b1;
      end
      if (push || skid_v_q) begin
        out_valid_q <= 1'b1;
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (pop) out_q <= skid_q;
    end else if (push) begin
      if (!out_valid_q || pop) begin
        out_q <= new_item;
      end else begin
        skid_q <= new_item;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign position_o     = out_q.position;
  assign velocity_o     = out_q.velocity;
  assign acceleration_o = out_q.acceleration;
  assign phase_o        = out_q.phase;
  assign saturated_o    = out_q.sat;

  // ---------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_valid_q)
    else $error("skid slot holds a result while the output register is empty");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_q && skid_v_q))
    else $error("input held off with room left at the output");

  a_skid_fill_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_v_q) |-> $past(out_valid_q && !out_ready_i && push))
    else $error("skid slot filled without a stalled output");

endmodule

FILE: tb/sv/poly_trajectory_evaluator_top_test.sv
`timescale 1ns / 1ps

module poly_trajectory_evaluator_top_test;
  import pte_pkg::*;

  localparam int          TRAJ_ORDER  = 5;
  localparam int          LATENCY     = 4 * TRAJ_ORDER + 1;
  localparam int          RAND_ROUNDS = 10;
  localparam int          ROUND_ITEMS = 185;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned MAX_REPORTS = 10;
  localparam longint      WORD_MAX    = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint      WORD_MIN    = -64'sh0000_8000_0000_0000;
  localparam logic [31:0] TIME_ONES   = 32'hFFFF_FFFF;

  // one evaluated trajectory point as it leaves the block
  typedef struct packed {
    pte_word_t  position;
    pte_word_t  velocity;
    pte_word_t  acceleration;
    pte_phase_e phase;
    logic       saturated;
  } traj_point_t;

  // directed rows: register write, sample checked by the predictor,
  // or sample with a hand-typed expectation
  typedef enum logic [1:0] {
    ROW_WRITE,
    ROW_SAMPLE,
    ROW_KNOWN
  } row_kind_e;

  typedef struct {
    row_kind_e   kind;
    pte_reg_e    reg_sel;
    logic [63:0] data;
    traj_point_t want;
  } stim_row_t;

  // how a random round picks its coefficients
  typedef enum logic [1:0] {
    STYLE_EDGE,
    STYLE_WILD,
    STYLE_MILD
  } setting_style_e;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic [TIME_W-1:0]        sample_time_i;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic signed [WORD_W-1:0] position_o;
  logic signed [WORD_W-1:0] velocity_o;
  logic signed [WORD_W-1:0] acceleration_o;
  logic [1:0]               phase_o;
  logic                     saturated_o;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [PADDR_W-1:0]       paddr;
  logic [PDATA_W-1:0]       pwdata;
  logic [PDATA_W-1:0]       prdata;
  logic                     pready;

  // shadow copy of the register file, as the predictor sees it
  longint      coef_sh [NUM_COEF];
  logic [31:0] start_sh;
  logic [31:0] dur_sh;
  bit          clip_seen;

  traj_point_t pending_points [$];
  stim_row_t   directed_plan [$];
  int unsigned burst_left   = 0;
  int unsigned sink_left    = 0;
  int unsigned cycle_count  = 0;
  int unsigned failures     = 0;
  int unsigned results_seen = 0;
  int unsigned clipped_seen = 0;
  int unsigned reg_writes   = 0;
  int unsigned phase_hits [3];

  poly_trajectory_evaluator_top #(
    .POLY_ORDER(TRAJ_ORDER)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .sample_time_i (sample_time_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .position_o    (position_o),
    .velocity_o    (velocity_o),
    .acceleration_o(acceleration_o),
    .phase_o       (phase_o),
    .saturated_o   (saturated_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // 8 ns clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // clip to the 48 bit range, remembering that it happened
  function automatic longint clip48(input longint x);
    if (x > WORD_MAX) begin
      clip_seen = 1'b1;
      return WORD_MAX;
    end
    if (x < WORD_MIN) begin
      clip_seen = 1'b1;
      return WORD_MIN;
    end
    return x;
  endfunction

  // a * b / 2^16 rounded to nearest, ties away from zero;
  // magnitude held at 2^48 so the following add still clips
  function automatic longint scale_q16(input longint a, input longint b);
    logic [63:0]  ua;
    logic [63:0]  ub;
    logic [127:0] mag;
    longint       r;
    ua  = (a < 0) ? -a : a;
    ub  = (b < 0) ? -b : b;
    mag = ({64'd0, ua} * {64'd0, ub} + 128'h8000) >> 16;
    if (mag > 128'h1_0000_0000_0000) mag = 128'h1_0000_0000_0000;
    r = longint'(mag[63:0]);
    return ((a < 0) != (b < 0)) ? -r : r;
  endfunction

  // position, velocity and acceleration at dt by Horner's rule, plus phase
  function automatic traj_point_t eval_trajectory(input logic [31:0] t);
    longint      lane_c [NUM_LANE][NUM_COEF];
    longint      res [NUM_LANE];
    longint      dt;
    longint      h;
    int          n;
    int          deg;
    traj_point_t p;
    n = (TRAJ_ORDER < 0) ? 0 : (TRAJ_ORDER > NUM_COEF - 1) ? NUM_COEF - 1 : TRAJ_ORDER;
    clip_seen = 1'b0;
    dt = longint'({32'd0, t}) - longint'({32'd0, start_sh});
    // derivative coefficients k*c_k and k*(k-1)*c_k, each clipped
    for (int k = 0; k < NUM_COEF; k++) begin
      lane_c[LANE_POS][k] = coef_sh[k];
      lane_c[LANE_VEL][k] = 0;
      lane_c[LANE_ACC][k] = 0;
      if (k < n) lane_c[LANE_VEL][k] = clip48(longint'(k + 1) * coef_sh[k + 1]);
      if (k < n - 1) begin
        lane_c[LANE_ACC][k] = clip48(longint'((k + 2) * (k + 1)) * coef_sh[k + 2]);
      end
    end
    // a lane whose degree drops below zero stays 0
    for (int ln = 0; ln < NUM_LANE; ln++) begin
      deg     = n - ln;
      res[ln] = 0;
      if (deg >= 0) begin
        h = lane_c[ln][deg];
        for (int k = deg - 1; k >= 0; k--) h = clip48(scale_q16(h, dt) + lane_c[ln][k]);
        res[ln] = h;
      end
    end
    p.position     = res[LANE_POS][WORD_W-1:0];
    p.velocity     = res[LANE_VEL][WORD_W-1:0];
    p.acceleration = res[LANE_ACC][WORD_W-1:0];
    // all-ones duration never finishes
    if (dt < 0) begin
      p.phase = PHASE_BEFORE;
    end else if (dur_sh == TIME_ONES) begin
      p.phase = PHASE_RUN;
    end else if (dt < longint'({32'd0, dur_sh})) begin
      p.phase = PHASE_RUN;
    end else begin
      p.phase = PHASE_DONE;
    end
    p.saturated = clip_seen;
    return p;
  endfunction

  task automatic report_failure(input string what, input traj_point_t want);
    failures++;
    if (failures <= MAX_REPORTS) begin
      $display("%0t %s: expected pos %h vel %h acc %h phase %0d sat %b", $realtime, what,
               want.position, want.velocity, want.acceleration, want.phase, want.saturated);
      $display("    got pos %h vel %h acc %h phase %0d sat %b",
               position_o, velocity_o, acceleration_o, phase_o, saturated_o);
    end
  endtask

  // one register write: setup, access, then the bus goes idle
  task automatic write_reg(input pte_reg_e sel, input logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, {REG_LSB{1'b0}}};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (sel)
      REG_START_TIME: start_sh = value[31:0];
      REG_DURATION:   dur_sh = value[31:0];
      default:        coef_sh[sel] = longint'(signed'(value[WORD_W-1:0]));
    endcase
    reg_writes++;
    @(posedge clk_i);
  endtask

  // sender works in bursts; between bursts valid drops for a random gap
  task automatic feed_sample(input logic [31:0] t, input bit known, input traj_point_t want);
    if (burst_left == 0) begin
      in_valid_i    <= 1'b0;
      sample_time_i <= $urandom;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
      burst_left = ($urandom_range(3) == 0) ? $urandom_range(64, 200) : $urandom_range(1, 24);
    end
    burst_left--;
    in_valid_i    <= 1'b1;
    sample_time_i <= t;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_points.insert(pending_points.size(), known ? want : eval_trajectory(t));
  endtask

  // stop sending and let every outstanding result come back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (pending_points.size() != 0) @(posedge clk_i);
  endtask

  task automatic plan_write(input pte_reg_e sel, input logic [63:0] value);
    stim_row_t r;
    r.kind    = ROW_WRITE;
    r.reg_sel = sel;
    r.data    = value;
    r.want    = '0;
    directed_plan.insert(directed_plan.size(), r);
  endtask

  task automatic plan_sample(input logic [31:0] t);
    stim_row_t r;
    r.kind    = ROW_SAMPLE;
    r.reg_sel = REG_COEF_0;
    r.data    = {32'd0, t};
    r.want    = '0;
    directed_plan.insert(directed_plan.size(), r);
  endtask

  // velocity and acceleration are zero in every hand-typed row
  task automatic plan_known(input logic [31:0] t, input longint pos, input pte_phase_e ph);
    stim_row_t r;
    r.kind               = ROW_KNOWN;
    r.reg_sel            = REG_COEF_0;
    r.data               = {32'd0, t};
    r.want               = '0;
    r.want.position      = pos[WORD_W-1:0];
    r.want.phase         = ph;
    directed_plan.insert(directed_plan.size(), r);
  endtask

  function automatic logic [63:0] rand_word(input int unsigned bits);
    logic [63:0] v;
    v = {$urandom, $urandom} & ((64'd1 << bits) - 64'd1);
    if ($urandom_range(1) == 1) v = -v;
    return v;
  endfunction

  // new register setting for one random round, all eight registers written
  task automatic load_random_setting(input int idx);
    setting_style_e style;
    logic [63:0]    v;
    style = (idx % 3 == 0) ? STYLE_EDGE : (idx % 3 == 1) ? STYLE_MILD : STYLE_WILD;
    for (int k = 0; k < NUM_COEF; k++) begin
      case (style)
        STYLE_EDGE: begin
          case ($urandom_range(3))
            0:       v = 64'(WORD_MAX);
            1:       v = 64'(WORD_MIN);
            2:       v = '0;
            default: v = '1;
          endcase
        end
        STYLE_MILD: v = rand_word($urandom_range(0, 47 - 6 * k));
        default:    v = ($urandom_range(1) == 0) ? {$urandom, $urandom}
                                                 : rand_word($urandom_range(0, 47));
      endcase
      write_reg(pte_reg_e'(k), v);
    end
    case ($urandom_range(3))
      0:       v = '0;
      1:       v = {32'd0, TIME_ONES};
      default: v = {$urandom, $urandom};
    endcase
    write_reg(REG_START_TIME, v);
    case ($urandom_range(4))
      0:       v = '0;
      1:       v = {32'd0, TIME_ONES};
      2:       v = {$urandom, $urandom};
      default: v = {32'd0, 32'($urandom_range(1, 1 << 20))};
    endcase
    write_reg(REG_DURATION, v);
  endtask

  // mostly near the start time, some at the finish edge, some anywhere
  function automatic logic [31:0] pick_sample_time();
    int unsigned span;
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: begin
        span = $urandom_range(2, 21);
        return start_sh + $urandom_range(0, (1 << span) - 1) - (1 << (span - 1));
      end
      6:       return start_sh + dur_sh + $urandom_range(0, 2) - 1;
      7:       return start_sh - $urandom_range(0, 1);
      default: return $urandom;
    endcase
  endfunction

  // receiver: ready runs and stall runs of random length
  always @(posedge clk_i) begin
    if (sink_left != 0) begin
      sink_left <= sink_left - 1;
    end else if ($urandom_range(1) == 0) begin
      out_ready_i <= 1'b0;
      sink_left   <= $urandom_range(0, 11);
    end else begin
      out_ready_i <= 1'b1;
      sink_left   <= $urandom_range(0, 80);
    end
  end

  // result checker: every result transfer against the oldest expectation
  always @(posedge clk_i) begin : result_check
    traj_point_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_points.size() == 0) begin
        report_failure("unexpected result", '0);
      end else begin
        want = pending_points.pop_front();
        results_seen++;
        phase_hits[want.phase]++;
        if (want.saturated) clipped_seen++;
        if (position_o !== want.position || velocity_o !== want.velocity ||
            acceleration_o !== want.acceleration || phase_o !== want.phase ||
            saturated_o !== want.saturated) begin
          report_failure("result mismatch", want);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_points.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin : stimulus
    stim_row_t row;
    // every input known from time zero
    rst_ni        <= 1'b0;
    in_valid_i    <= 1'b0;
    sample_time_i <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    // register values after reset
    foreach (coef_sh[k]) coef_sh[k] = 0;
    start_sh = TIME_ONES;
    dur_sh   = '0;
    foreach (phase_hits[k]) phase_hits[k] = 0;

    // reset state: start at all ones, so only the very last time has started,
    // and with zero duration it is already finished
    plan_known(32'h0000_0000, 0, PHASE_BEFORE);
    plan_known(32'h7FFF_FFFF, 0, PHASE_BEFORE);
    plan_known(TIME_ONES, 0, PHASE_DONE);
    // constant at the extremes, never-ending trajectory from time zero
    plan_write(REG_COEF_0, 64'(WORD_MAX));
    plan_write(REG_START_TIME, '0);
    plan_write(REG_DURATION, {32'd0, TIME_ONES});
    plan_known(32'h0000_0000, WORD_MAX, PHASE_RUN);
    plan_known(TIME_ONES, WORD_MAX, PHASE_RUN);
    plan_write(REG_COEF_0, 64'(WORD_MIN));
    plan_known(TIME_ONES, WORD_MIN, PHASE_RUN);
    // most negative top coefficient: derivative coefficients clip
    plan_write(REG_COEF_5, 64'(WORD_MIN));
    plan_sample(32'h0000_0000);
    plan_sample(32'h0001_0000);
    plan_sample(TIME_ONES);
    // ordinary quintic, start mid-range, one second long
    plan_write(REG_COEF_0, '0);
    plan_write(REG_COEF_1, 64'd1 << 24);
    plan_write(REG_COEF_2, -(64'd3 << 23));
    plan_write(REG_COEF_3, 64'd1 << 22);
    plan_write(REG_COEF_4, '1);
    plan_write(REG_COEF_5, 64'd3);
    plan_write(REG_START_TIME, 64'h8000_0000);
    plan_write(REG_DURATION, 64'h0001_0000);
    plan_sample(32'h0000_0000);
    plan_sample(32'h7FFF_FFFF);
    plan_sample(32'h8000_0000);
    plan_sample(32'h8000_8000);
    plan_sample(32'h8000_FFFF);
    plan_sample(32'h8001_0000);
    plan_sample(TIME_ONES);
    // zero duration finishes at the start instant
    plan_write(REG_DURATION, '0);
    plan_sample(32'h8000_0000);
    // all coefficients one lsb negative, rounding ties on both signs of dt
    for (int k = 0; k < NUM_COEF; k++) plan_write(pte_reg_e'(k), '1);
    plan_write(REG_START_TIME, 64'h0001_0000);
    plan_write(REG_DURATION, 64'hFFFF_FFFE);
    plan_sample(32'h0001_8000);
    plan_sample(32'h0000_8000);
    plan_sample(TIME_ONES);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed part; registers change only with the pipeline empty
    foreach (directed_plan[i]) begin
      row = directed_plan[i];
      if (row.kind == ROW_WRITE) begin
        drain_results();
        write_reg(row.reg_sel, row.data);
      end else begin
        feed_sample(row.data[31:0], row.kind == ROW_KNOWN, row.want);
      end
    end

    // random rounds, each with its own register setting
    for (int r = 0; r < RAND_ROUNDS; r++) begin
      drain_results();
      load_random_setting(r);
      for (int i = 0; i < ROUND_ITEMS; i++) feed_sample(pick_sample_time(), 1'b0, '0);
    end

    drain_results();
    // watch for stray results after the last expected one
    repeat (2 * LATENCY) @(posedge clk_i);

    if (pending_points.size() != 0) begin
      failures += pending_points.size();
      $display("%0d expected results never arrived", pending_points.size());
    end
    $display("%0d trajectory points checked over %0d register writes, %0d with clipping",
             results_seen, reg_writes, clipped_seen);
    $display("phases seen: before start %0d, running %0d, finished %0d",
             phase_hits[PHASE_BEFORE], phase_hits[PHASE_RUN], phase_hits[PHASE_DONE]);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
